// ===== sv/lru_key_value_cache_assert.svh =====
// Assertion macros shared by the cache RTL.
// Both expect signals named clk and arst_n in the including scope.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lkv_pkg.sv =====
package lkv_pkg;

	localparam logic       REQ_GET    = 1'b0;
	localparam logic       REQ_SET    = 1'b1;
	localparam logic [6:0] CAP_RESET  = 7'd64;
	localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
	} rsp_t;

	// Control from the sequencer to the scan unit.
	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

	// What the scan unit has found so far.
	typedef struct packed {
		logic match;
		logic oldest;
		logic free;
	} scan_flags_t;

endpackage

// ===== sv/lkv_ram.sv =====
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/lkv_scan.sv =====
module lkv_scan #(
	parameter int IW = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lkv_pkg::scan_ctl_t     ctl,
	input  logic [IW-1:0]          idx,
	input  logic [31:0]            key_ref,
	input  logic [31:0]            key_rd,
	input  logic [31:0]            value_rd,
	input  logic                   entry_valid,
	input  logic [IW-1:0]          entry_rank,
	output lkv_pkg::scan_flags_t   flags,
	output logic [IW-1:0]          match_idx,
	output logic [IW-1:0]          match_rank,
	output logic [31:0]            match_value,
	output logic [IW-1:0]          old_idx,
	output logic [IW-1:0]          free_idx
);

	lkv_pkg::scan_flags_t flags_q;
	logic [IW-1:0]        match_idx_q;
	logic [IW-1:0]        match_rank_q;
	logic [31:0]          match_value_q;
	logic [IW-1:0]        old_idx_q;
	logic [IW-1:0]        old_rank_q;
	logic [IW-1:0]        free_idx_q;
	logic                 take_match;
	logic                 take_old;
	logic                 take_free;

	// One entry per cycle through the key comparator and the rank comparator.
	always_comb begin
		take_match = ctl.sample && entry_valid && (key_rd == key_ref) && !flags_q.match;
		take_old   = ctl.sample && entry_valid && (!flags_q.oldest || (entry_rank > old_rank_q));
		take_free  = ctl.sample && !entry_valid && !flags_q.free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctl.clear) begin
			flags_q <= '0;
		end else begin
			if (take_match) flags_q.match  <= 1'b1;
			if (take_old)   flags_q.oldest <= 1'b1;
			if (take_free)  flags_q.free   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			match_idx_q   <= idx;
			match_rank_q  <= entry_rank;
			match_value_q <= value_rd;
		end
		if (take_old) begin
			old_idx_q  <= idx;
			old_rank_q <= entry_rank;
		end
		if (take_free) begin
			free_idx_q <= idx;
		end
	end

	assign flags       = flags_q;
	assign match_idx   = match_idx_q;
	assign match_rank  = match_rank_q;
	assign match_value = match_value_q;
	assign old_idx     = old_idx_q;
	assign free_idx    = free_idx_q;

endmodule

// ===== sv/lru_key_value_cache.sv =====
// Key-value cache with least-recently-used replacement.
// Requests arrive on req (req_valid/req_stall): a get looks up req.key, a set
// writes req.value under req.key. Each get yields one transaction on rsp
// (rsp_valid/rsp_stall) carrying the hit flag and the stored value, or -1 on a
// miss; a set yields nothing. Capacity is written through cfg_valid/cfg_data
// (cfg_ready is always high) and should only change while the cache is idle.
// Each request is handled by a sequencer around one scan unit and three RAMs.
// A scan pass reads every slot once, one per cycle, looking for the key, the
// least recent entry and a free slot; the response is registered in the decide
// state after the pass. A hit or a set then needs a second pass that rewrites
// the recency rank of every slot, one per cycle, while a get miss goes back to
// idle from the decide state. req_stall is high whenever a request is in
// progress. After reset a clearing pass marks every slot free; requests are
// held off until it ends. Capacity resets to 64.
// A pending response waits in its output register while rsp_stall is high; the
// next request is still accepted and scanned, and a get then waits in the
// decide state until the register is free.
module lru_key_value_cache #(
	parameter int ENTRIES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lkv_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lkv_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [6:0]    cfg_data
);

	`include "lru_key_value_cache_assert.svh"

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MW = IW + 1;
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int CW = (OW > 7) ? OW : 7;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;

	logic [2:0]           state_q;
	logic [IW-1:0]        ptr_q;
	logic                 issue_q;
	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [OW-1:0]        occ_q;
	logic [6:0]           cap_q;
	lkv_pkg::req_t        req_q;
	logic                 rsp_valid_q;
	lkv_pkg::rsp_t        rsp_q;
	logic [IW-1:0]        tgt_q;
	logic                 touch_q;
	logic [IW-1:0]        touch_rank_q;

	lkv_pkg::scan_ctl_t   scan_ctl;
	lkv_pkg::scan_flags_t flags;
	logic [IW-1:0]        match_idx;
	logic [IW-1:0]        match_rank;
	logic [31:0]          match_value;
	logic [IW-1:0]        old_idx;
	logic [IW-1:0]        free_idx;

	logic [31:0]          key_rd;
	logic [31:0]          value_rd;
	logic [MW-1:0]        meta_rd;
	logic                 m_valid;
	logic [IW-1:0]        m_rank;
	logic [MW-1:0]        meta_new;
	logic                 meta_we;
	logic [IW-1:0]        meta_waddr;
	logic [MW-1:0]        meta_wdata;
	logic                 key_we;
	logic                 value_we;

	logic                 op_set;
	logic                 can_out;
	logic                 dec_wait;
	logic                 dec_go;
	logic                 dec_insert;
	logic                 rsp_load;
	logic                 evict;
	logic [IW-1:0]        tgt_d;
	logic                 sweep_end;
	logic [CW-1:0]        cap_ext;
	logic [CW-1:0]        eff_cap;

	always_comb begin
		req_stall  = (state_q != ST_IDLE);
		op_set     = (req_q.req_type == lkv_pkg::REQ_SET);
		can_out    = !rsp_valid_q || !rsp_stall;
		dec_wait   = (state_q == ST_DECIDE) && !op_set && !can_out;
		dec_go     = (state_q == ST_DECIDE) && !dec_wait;
		rsp_load   = (state_q == ST_DECIDE) && !op_set && can_out;
		dec_insert = (state_q == ST_DECIDE) && op_set && !flags.match;
		sweep_end  = rd_vld_s1 && (rd_idx_s1 == LAST);

		// Capacity zero acts as one; anything above the slot count saturates.
		cap_ext = CW'(cap_q);
		if (cap_ext == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		evict = (CW'(occ_q) >= eff_cap);

		if (flags.match) begin
			tgt_d = match_idx;
		end else if (evict) begin
			tgt_d = old_idx;
		end else begin
			tgt_d = free_idx;
		end

		scan_ctl.clear  = (state_q == ST_IDLE) && req_valid;
		scan_ctl.sample = (state_q == ST_SCAN) && rd_vld_s1;
	end

	// Recency rewrite for the slot whose ranks have just been read.
	always_comb begin
		m_valid = meta_rd[IW];
		m_rank  = meta_rd[IW-1:0];
		if (rd_idx_s1 == tgt_q) begin
			meta_new = {1'b1, {IW{1'b0}}};
		end else if (touch_q) begin
			if (m_valid && (m_rank < touch_rank_q)) begin
				meta_new = {1'b1, m_rank + IW'(1)};
			end else begin
				meta_new = meta_rd;
			end
		end else if (m_valid) begin
			meta_new = {1'b1, m_rank + IW'(1)};
		end else begin
			meta_new = meta_rd;
		end

		meta_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPDATE) && rd_vld_s1);
		meta_waddr = (state_q == ST_CLEAR) ? ptr_q : rd_idx_s1;
		meta_wdata = (state_q == ST_CLEAR) ? '0 : meta_new;
		key_we     = dec_insert;
		value_we   = (state_q == ST_DECIDE) && op_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ptr_q       <= '0;
			issue_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
			occ_q       <= '0;
			cap_q       <= lkv_pkg::CAP_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			rd_vld_s1 <= issue_q;

			unique case (state_q)
				ST_CLEAR: begin
					if (ptr_q == LAST) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + IW'(1);
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SCAN;
						issue_q <= 1'b1;
						ptr_q   <= '0;
					end
				end
				ST_SCAN, ST_UPDATE: begin
					if (issue_q) begin
						if (ptr_q == LAST) begin
							issue_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q + IW'(1);
						end
					end
					if (sweep_end) begin
						state_q <= (state_q == ST_SCAN) ? ST_DECIDE : ST_IDLE;
					end
				end
				ST_DECIDE: begin
					if (dec_go) begin
						if (!op_set && !flags.match) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_UPDATE;
							issue_q <= 1'b1;
							ptr_q   <= '0;
						end
					end
					// An eviction frees one slot and the insert fills it again.
					if (dec_insert && !evict) begin
						occ_q <= occ_q + OW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q;
		if ((state_q == ST_IDLE) && req_valid) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q.hit        <= flags.match;
			rsp_q.read_value <= flags.match ? match_value : lkv_pkg::MISS_VALUE;
		end
		if (dec_go) begin
			tgt_q        <= tgt_d;
			touch_q      <= flags.match;
			touch_rank_q <= match_rank;
		end
	end

	lkv_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (tgt_d),
		.wdata (req_q.key),
		.raddr (ptr_q),
		.rdata (key_rd)
	);

	lkv_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_value_ram (
		.clk   (clk),
		.we    (value_we),
		.waddr (tgt_d),
		.wdata (req_q.value),
		.raddr (ptr_q),
		.rdata (value_rd)
	);

	// Valid bit above the recency rank; the clearing pass zeroes it.
	lkv_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (ptr_q),
		.rdata (meta_rd)
	);

	lkv_scan #(.IW(IW)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.idx         (rd_idx_s1),
		.key_ref     (req_q.key),
		.key_rd      (key_rd),
		.value_rd    (value_rd),
		.entry_valid (meta_rd[IW]),
		.entry_rank  (meta_rd[IW-1:0]),
		.flags       (flags),
		.match_idx   (match_idx),
		.match_rank  (match_rank),
		.match_value (match_value),
		.old_idx     (old_idx),
		.free_idx    (free_idx)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	`LKV_ASSERT_HOLDS(a_free_slot_found, dec_insert && !evict, flags.free, "insert without a free slot")
	`LKV_ASSERT_HOLDS(a_victim_found, dec_insert && evict, flags.oldest, "eviction without a valid entry")
	`LKV_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request not held off")
	`LKV_ASSERT_HOLDS(a_rsp_from_get, $rose(rsp_valid), $past(rsp_load), "response without a get")

endmodule

// ===== test/lru_cache_checker.sv =====
module lru_cache_checker #(
	parameter int SLOTS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  lkv_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  lkv_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [6:0]    cfg_data,
	output int            fail_count,
	output int            outstanding,
	output int            lookups,
	output int            hits
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [6:0]    cap_reg;
	logic [31:0]   slot_key [SLOTS];
	logic [31:0]   slot_val [SLOTS];
	bit            slot_used [SLOTS];
	int unsigned   slot_age [SLOTS];
	int unsigned   used_count;
	lkv_pkg::rsp_t answers [$];

	function automatic int unsigned live_capacity();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > SLOTS)
			return SLOTS;
		return {25'd0, cap_reg};
	endfunction

	function automatic int find_slot(logic [31:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	// Entries that were more recent than slot s age by one; s becomes the newest.
	function automatic void promote(int s);
		int unsigned old_age;
		old_age = slot_age[s];
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && i != s && slot_age[i] < old_age)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	function automatic void apply_request(lkv_pkg::req_t r);
		int            found;
		int            victim;
		lkv_pkg::rsp_t ans;
		found = find_slot(r.key);
		if (r.req_type == lkv_pkg::REQ_GET) begin
			lookups++;
			if (found >= 0) begin
				promote(found);
				ans.hit = 1'b1;
				ans.read_value = slot_val[found];
				hits++;
			end else begin
				ans.hit = 1'b0;
				ans.read_value = lkv_pkg::MISS_VALUE;
			end
			answers.push_back(ans);
		end else if (found >= 0) begin
			slot_val[found] = r.value;
			promote(found);
		end else begin
			victim = -1;
			// A full cache gives up its oldest entry; the first of equal age wins.
			if (used_count >= live_capacity()) begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
						victim = i;
				if (victim >= 0) begin
					slot_used[victim] = 1'b0;
					used_count--;
				end
			end
			if (victim < 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (!slot_used[i]) begin
						victim = i;
						break;
					end
			end
			for (int i = 0; i < SLOTS; i++)
				if (slot_used[i])
					slot_age[i]++;
			slot_key[victim] = r.key;
			slot_val[victim] = r.value;
			slot_used[victim] = 1'b1;
			slot_age[victim] = 0;
			used_count++;
		end
	endfunction

	function automatic void check_response(lkv_pkg::rsp_t got);
		lkv_pkg::rsp_t want;
		if (answers.size() == 0) begin
			$error("response transaction with no lookup waiting: hit %0b read_value %h",
				got.hit, got.read_value);
			fail_count++;
			return;
		end
		want = answers.pop_front();
		if (got.hit !== want.hit) begin
			$error("hit: expected %0b, actual %0b", want.hit, got.hit);
			fail_count++;
		end
		if (got.read_value !== want.read_value) begin
			$error("read_value: expected %h, actual %h", want.read_value, got.read_value);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_reg = lkv_pkg::CAP_RESET;
			for (int i = 0; i < SLOTS; i++)
				slot_used[i] = 1'b0;
			used_count = 0;
			answers.delete();
			fail_count = 0;
			lookups = 0;
			hits = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_reg = cfg_data;
			if (req_valid && !req_stall)
				apply_request(req);
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
		end
		outstanding = answers.size();
	end

endmodule

// ===== test/tb_lru_key_value_cache.sv =====
module tb_lru_key_value_cache;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 64;
	localparam int SETTLE      = 2 * DEPTH + 40;
	localparam int HOLD_CYCLES = 1500;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	lkv_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	lkv_pkg::rsp_t rsp;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [6:0]    cfg_data = '0;

	int failures;
	int outstanding;
	int lookups;
	int hits;
	int sent = 0;
	int cfg_writes = 0;

	bit hold_rsp = 1'b0;
	bit steady = 1'b0;

	logic [31:0] key_pool [$];

	always #5 clk = ~clk;

	lru_key_value_cache #(.ENTRIES(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lru_cache_checker #(.SLOTS(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (failures),
		.outstanding (outstanding),
		.lookups     (lookups),
		.hits        (hits)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (r < 95)
			return $urandom;
		return extreme_word();
	endfunction

	task automatic send_request(input logic kind, input logic [31:0] k, input logic [31:0] v);
		int gap;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= lkv_pkg::req_t'{kind, k, v};
		do @(posedge clk); while (req_stall);
		sent++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Sets give no response, so the cache may still be busy once the last one is in.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [6:0] c);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	initial begin
		int len;
		forever begin
			if (hold_rsp) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_rsp = 1'b0;
			end else if (steady) begin
				@(negedge clk);
				rsp_stall <= 1'b0;
			end else begin
				len = pick_gap();
				if (len > 0) begin
					@(negedge clk);
					rsp_stall <= 1'b1;
					repeat (len - 1) @(negedge clk);
				end
				@(negedge clk);
				rsp_stall <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
	end

	initial begin
		logic [6:0] cap_val;
		int         count;
		int         live;
		logic       kind;
		logic [31:0] val;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Two entries: refresh on a hit decides which one is evicted.
		write_capacity(7'd2);
		send_request(lkv_pkg::REQ_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(lkv_pkg::REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(lkv_pkg::REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(lkv_pkg::REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(lkv_pkg::REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(lkv_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(lkv_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h1234_5678);
		send_request(lkv_pkg::REQ_SET, 32'h8000_0000, 32'h0000_0000);
		send_request(lkv_pkg::REQ_GET, 32'h8000_0000, 32'h0000_0000);

		// A capacity of zero behaves as one.
		drain();
		write_capacity(7'd0);
		send_request(lkv_pkg::REQ_SET, 32'd5, 32'd55);
		send_request(lkv_pkg::REQ_SET, 32'd6, 32'd66);
		send_request(lkv_pkg::REQ_GET, 32'd5, 32'd0);
		send_request(lkv_pkg::REQ_GET, 32'd6, 32'd0);

		drain();
		write_capacity(7'd64);
		send_request(lkv_pkg::REQ_SET, 32'd100, 32'd1000);
		send_request(lkv_pkg::REQ_SET, 32'd101, 32'd1001);
		send_request(lkv_pkg::REQ_SET, 32'd102, 32'd1002);

		// Capacity dropped below occupancy: each new key costs exactly one entry.
		drain();
		write_capacity(7'd1);
		send_request(lkv_pkg::REQ_SET, 32'd200, 32'd2000);
		send_request(lkv_pkg::REQ_GET, 32'd6, 32'd0);
		send_request(lkv_pkg::REQ_GET, 32'd100, 32'd0);
		send_request(lkv_pkg::REQ_GET, 32'd102, 32'd0);
		send_request(lkv_pkg::REQ_SET, 32'd101, 32'd7);
		send_request(lkv_pkg::REQ_GET, 32'd101, 32'd0);

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin cap_val = 7'd1;   count = 60;  end
				1: begin cap_val = 7'd3;   count = 80;  end
				2: begin cap_val = 7'd17;  count = 100; end
				3: begin cap_val = 7'd127; count = 150; end
				4: begin cap_val = 7'd40;  count = 100; end
				5: begin cap_val = 7'd0;   count = 50;  end
				default: begin cap_val = 7'd64; count = 110; end
			endcase
			drain();
			write_capacity(cap_val);

			// A pool slightly larger than the capacity gives both hits and evictions.
			live = (cap_val == 0) ? 1 : ((cap_val > DEPTH) ? DEPTH : int'(cap_val));
			key_pool.delete();
			repeat (live + live / 4 + 2) key_pool.push_back($urandom);

			steady = (p == 1);
			if (p == 2)
				hold_rsp = 1'b1;
			for (int n = 0; n < count; n++) begin
				kind = ($urandom_range(0, 99) < 55) ? lkv_pkg::REQ_SET : lkv_pkg::REQ_GET;
				val = ($urandom_range(0, 4) == 0) ? extreme_word() : $urandom;
				send_request(kind, pick_key(), val);
			end
			steady = 1'b0;
		end
		drain();

		$display("Covered %0d requests, %0d of them lookups with %0d hits, over %0d capacity writes.",
			sent, lookups, hits, cfg_writes);
		if (failures == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
